@@ design/assert_macros.svh @@
// Assertion macros used by the chunk walker controller.
// Each macro expects the signals clk and rst_n to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PCW_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define PCW_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/pcw_pkg.sv @@
// Shared types, constants and arithmetic helpers of the pyramid chunk walker.
// Has no dependencies; every other design module refers to it by scoped names.
package pcw_pkg;

    localparam int MAX_LEVELS = 16;
    localparam int COORD_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_LEVELS);
    localparam int LEVEL_W    = IDX_W + 1;
    localparam int WORK_W     = COORD_BITS + 1;
    localparam int SHAPE_W    = 31;
    localparam int CSZ_W      = 12;
    localparam int DIVS_W     = CSZ_W + 1;
    localparam int DIVCNT_W   = $clog2(COORD_BITS);
    localparam int AXES       = 3;

    // Request command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_Z_BEGIN = 3'd0;
    localparam logic [2:0] REG_Y_BEGIN = 3'd1;
    localparam logic [2:0] REG_X_BEGIN = 3'd2;
    localparam logic [2:0] REG_Z_END   = 3'd3;
    localparam logic [2:0] REG_Y_END   = 3'd4;
    localparam logic [2:0] REG_X_END   = 3'd5;
    localparam logic [2:0] REG_LEVELS  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,
        S_HALVE,
        S_CLAMP,
        S_DIVIDE,
        S_CHECK,
        S_FINISH
    } pcw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_meta;
        logic start_level;
        logic seek_load;
        logic halve_step;
        logic clamp_load;
        logic div_step;
        logic level_dec;
        logic commit;
        logic set_done;
        logic advance;
        logic emit;
        logic emit_done;
    } pcw_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic level_neg;
        logic halve_done;
        logic div_done;
        logic level_ok;
        logic wrap_last;
        logic walk_done;
        logic out_pending;
    } pcw_sts_t;

    // Halve rounding up for non-negative values; for negative ones, halve v + 1 toward zero.
    function automatic logic signed [WORK_W-1:0] halve_up(input logic signed [WORK_W-1:0] v);
        logic signed [WORK_W-1:0] x;
        x = v + WORK_W'(1);
        return (x >>> 1) + signed'(WORK_W'(x[WORK_W-1] & x[0]));
    endfunction

    // Halve truncating toward zero.
    function automatic logic signed [WORK_W-1:0] half_trunc(input logic signed [WORK_W-1:0] v);
        return (v >>> 1) + signed'(WORK_W'(v[WORK_W-1] & v[0]));
    endfunction

endpackage

@@ design/pcw_ctrl.sv @@
// Controller of the pyramid chunk walker: request decode and the level search sequence.
// Depends on pcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       cmd,
    input  pcw_pkg::pcw_sts_t sts,
    output pcw_pkg::pcw_ctl_t ctl
);

    pcw_pkg::pcw_state_t state_reg, state_next;
    logic from_next_reg, from_next_next;
    logic accept;

    // A request is taken only when idle and no result is waiting.
    assign req_stall = (state_reg != pcw_pkg::S_IDLE) || sts.out_pending;
    assign accept    = req_valid && !req_stall;

    // State and origin registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcw_pkg::S_IDLE;
            from_next_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            from_next_reg <= from_next_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next     = state_reg;
        from_next_next = from_next_reg;
        case (state_reg)
            pcw_pkg::S_IDLE:
            begin
                if (accept && cmd == pcw_pkg::CMD_START)
                begin
                    state_next     = pcw_pkg::S_SEEK;
                    from_next_next = 1'b0;
                end
                else if (accept && cmd == pcw_pkg::CMD_NEXT && !sts.walk_done && sts.wrap_last)
                begin
                    state_next     = pcw_pkg::S_SEEK;
                    from_next_next = 1'b1;
                end
            end
            pcw_pkg::S_SEEK:
            begin
                state_next = sts.level_neg ? pcw_pkg::S_FINISH : pcw_pkg::S_HALVE;
            end
            pcw_pkg::S_HALVE:
            begin
                if (sts.halve_done)
                    state_next = pcw_pkg::S_CLAMP;
            end
            pcw_pkg::S_CLAMP:  state_next = pcw_pkg::S_DIVIDE;
            pcw_pkg::S_DIVIDE:
            begin
                if (sts.div_done)
                    state_next = pcw_pkg::S_CHECK;
            end
            pcw_pkg::S_CHECK:
            begin
                state_next = sts.level_ok ? pcw_pkg::S_FINISH : pcw_pkg::S_SEEK;
            end
            pcw_pkg::S_FINISH: state_next = pcw_pkg::S_IDLE;
            default:           state_next = pcw_pkg::S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            pcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        pcw_pkg::CMD_LOAD:  ctl.load_meta   = 1'b1;
                        pcw_pkg::CMD_START: ctl.start_level = 1'b1;
                        pcw_pkg::CMD_NEXT:
                        begin
                            if (sts.walk_done)
                                ctl.emit_done = 1'b1;
                            else
                            begin
                                ctl.advance = 1'b1;
                                if (sts.wrap_last)
                                    ctl.level_dec = 1'b1;
                                else
                                    ctl.emit = 1'b1;
                            end
                        end
                        default: ctl = '0;
                    endcase
                end
            end
            pcw_pkg::S_SEEK:
            begin
                if (sts.level_neg)
                    ctl.set_done = 1'b1;
                else
                    ctl.seek_load = 1'b1;
            end
            pcw_pkg::S_HALVE:
            begin
                if (!sts.halve_done)
                    ctl.halve_step = 1'b1;
            end
            pcw_pkg::S_CLAMP:  ctl.clamp_load = 1'b1;
            pcw_pkg::S_DIVIDE: ctl.div_step   = 1'b1;
            pcw_pkg::S_CHECK:
            begin
                if (sts.level_ok)
                    ctl.commit = 1'b1;
                else
                    ctl.level_dec = 1'b1;
            end
            pcw_pkg::S_FINISH: ctl.emit = from_next_reg;
            default:           ctl = '0;
        endcase
    end

    `PCW_ASSERT(a_emit_free, !((ctl.emit || ctl.emit_done) && sts.out_pending), "result overwritten")
    `PCW_ASSERT_NEXT(a_clamp_div, state_reg == pcw_pkg::S_CLAMP, state_reg == pcw_pkg::S_DIVIDE, "clamp not followed by divide")
    `PCW_ASSERT_NEXT(a_finish_idle, state_reg == pcw_pkg::S_FINISH, state_reg == pcw_pkg::S_IDLE && !req_stall == !sts.out_pending, "finish not followed by idle")

endmodule

@@ design/pcw_dp.sv @@
// Datapath of the pyramid chunk walker: level table, bound scaling, dividers, cursors, result.
// Depends on pcw_pkg.
module pcw_dp (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  pcw_pkg::pcw_ctl_t                              ctl,
    output pcw_pkg::pcw_sts_t                              sts,
    input  logic [pcw_pkg::COORD_BITS-1:0]                 region_begin [pcw_pkg::AXES],
    input  logic [pcw_pkg::COORD_BITS-1:0]                 region_end [pcw_pkg::AXES],
    input  logic [pcw_pkg::LEVEL_W-1:0]                    level_count,
    input  logic [pcw_pkg::IDX_W-1:0]                      level_index,
    input  logic [pcw_pkg::SHAPE_W-1:0]                    vol_shape [pcw_pkg::AXES],
    input  logic [12:0]                                    blk_shape [pcw_pkg::AXES],
    input  logic                                           rsp_stall,
    output logic                                           rsp_valid,
    output logic                                           chunk_valid,
    output logic [3:0]                                     chunk_level,
    output logic [pcw_pkg::SHAPE_W-1:0]                    chunk_index [pcw_pkg::AXES],
    output logic                                           level_last,
    output logic                                           walk_finished
);

    localparam int W  = pcw_pkg::WORK_W;
    localparam int CB = pcw_pkg::COORD_BITS;
    localparam int SW = pcw_pkg::SHAPE_W;

    // Level table, chunk sizes held as size minus one.
    logic [SW-1:0]             meta_shape_reg [pcw_pkg::AXES][pcw_pkg::MAX_LEVELS];
    logic [pcw_pkg::CSZ_W-1:0] meta_chunk_reg [pcw_pkg::AXES][pcw_pkg::MAX_LEVELS];

    logic [pcw_pkg::LEVEL_W-1:0]  level_reg;
    logic [pcw_pkg::IDX_W-1:0]    step_cnt_reg;
    logic                         first_step_reg;
    logic signed [W-1:0]          work_lo_reg [pcw_pkg::AXES];
    logic signed [W-1:0]          work_hi_reg [pcw_pkg::AXES];
    logic [CB-1:0]                div_lo_reg [pcw_pkg::AXES];
    logic [CB-1:0]                div_hi_reg [pcw_pkg::AXES];
    logic [pcw_pkg::CSZ_W-1:0]    rem_lo_reg [pcw_pkg::AXES];
    logic [pcw_pkg::CSZ_W-1:0]    rem_hi_reg [pcw_pkg::AXES];
    logic                         hi_neg_reg [pcw_pkg::AXES];
    logic [pcw_pkg::DIVCNT_W-1:0] div_cnt_reg;
    logic [SW-1:0]                bound_lo_reg [pcw_pkg::AXES];
    logic [SW-1:0]                bound_hi_reg [pcw_pkg::AXES];
    logic [SW-1:0]                cursor_reg [pcw_pkg::AXES];
    logic                         done_reg;
    logic                         rsp_valid_reg;

    logic [pcw_pkg::LEVEL_W-1:0]  levels_used;
    logic [pcw_pkg::IDX_W-1:0]    lvl_idx;
    logic [pcw_pkg::DIVS_W-1:0]   divisor [pcw_pkg::AXES];
    logic [SW-1:0]                cur_shape [pcw_pkg::AXES];
    logic [pcw_pkg::DIVS_W:0]     trial_lo [pcw_pkg::AXES];
    logic [pcw_pkg::DIVS_W:0]     trial_hi [pcw_pkg::AXES];
    logic                         axis_ok [pcw_pkg::AXES];
    logic                         at_hi [pcw_pkg::AXES];

    assign lvl_idx = level_reg[pcw_pkg::IDX_W-1:0];
    assign levels_used = (level_count > pcw_pkg::LEVEL_W'(pcw_pkg::MAX_LEVELS))
                       ? pcw_pkg::LEVEL_W'(pcw_pkg::MAX_LEVELS) : level_count;

    // Per-axis table read, divider trial subtracts, level check and cursor end compare.
    always_comb
    begin
        for (int a = 0; a < pcw_pkg::AXES; a++)
        begin
            cur_shape[a] = meta_shape_reg[a][lvl_idx];
            divisor[a]   = {1'b0, meta_chunk_reg[a][lvl_idx]} + pcw_pkg::DIVS_W'(1);
            trial_lo[a]  = {1'b0, rem_lo_reg[a], div_lo_reg[a][CB-1]} - {1'b0, divisor[a]};
            trial_hi[a]  = {1'b0, rem_hi_reg[a], div_hi_reg[a][CB-1]} - {1'b0, divisor[a]};
            if (hi_neg_reg[a] && div_hi_reg[a] != '0)
                axis_ok[a] = 1'b0;
            else
                axis_ok[a] = div_lo_reg[a] <= div_hi_reg[a];
            at_hi[a] = cursor_reg[a] == bound_hi_reg[a];
        end
    end

    assign sts.level_neg   = level_reg[pcw_pkg::LEVEL_W-1];
    assign sts.halve_done  = step_cnt_reg == '0;
    assign sts.div_done    = div_cnt_reg == '1;
    assign sts.level_ok    = axis_ok[0] && axis_ok[1] && axis_ok[2];
    assign sts.wrap_last   = at_hi[0] && at_hi[1] && at_hi[2];
    assign sts.walk_done   = done_reg;
    assign sts.out_pending = rsp_valid_reg;

    // Level table writes.
    always_ff @(posedge clk)
    begin
        if (ctl.load_meta)
        begin
            for (int a = 0; a < pcw_pkg::AXES; a++)
            begin
                meta_shape_reg[a][level_index] <= vol_shape[a];
                meta_chunk_reg[a][level_index] <= pcw_pkg::CSZ_W'(blk_shape[a] - 13'd1);
            end
        end
    end

    // Bound scaling and per-axis division lanes.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < pcw_pkg::AXES; a++)
        begin
            if (ctl.seek_load)
            begin
                work_lo_reg[a] <= W'(signed'(region_begin[a]));
                if (level_reg == '0)
                    work_hi_reg[a] <= W'(signed'(region_end[a])) - W'(1);
                else
                    work_hi_reg[a] <= W'(signed'(region_end[a]));
            end
            else if (ctl.halve_step)
            begin
                work_lo_reg[a] <= pcw_pkg::halve_up(work_lo_reg[a]);
                work_hi_reg[a] <= first_step_reg ? pcw_pkg::half_trunc(work_hi_reg[a])
                                                 : pcw_pkg::halve_up(work_hi_reg[a]);
            end
            if (ctl.clamp_load)
            begin
                logic signed [W-1:0] b;
                b = (work_hi_reg[a] >= signed'(W'(cur_shape[a])))
                  ? signed'(W'(cur_shape[a]) - W'(1)) : work_hi_reg[a];
                div_lo_reg[a] <= work_lo_reg[a][W-1] ? '0 : work_lo_reg[a][CB-1:0];
                div_hi_reg[a] <= b[W-1] ? CB'(-b) : b[CB-1:0];
                hi_neg_reg[a] <= b[W-1];
                rem_lo_reg[a] <= '0;
                rem_hi_reg[a] <= '0;
            end
            else if (ctl.div_step)
            begin
                if (!trial_lo[a][pcw_pkg::DIVS_W])
                begin
                    rem_lo_reg[a] <= trial_lo[a][pcw_pkg::CSZ_W-1:0];
                    div_lo_reg[a] <= {div_lo_reg[a][CB-2:0], 1'b1};
                end
                else
                begin
                    rem_lo_reg[a] <= {rem_lo_reg[a][pcw_pkg::CSZ_W-2:0], div_lo_reg[a][CB-1]};
                    div_lo_reg[a] <= {div_lo_reg[a][CB-2:0], 1'b0};
                end
                if (!trial_hi[a][pcw_pkg::DIVS_W])
                begin
                    rem_hi_reg[a] <= trial_hi[a][pcw_pkg::CSZ_W-1:0];
                    div_hi_reg[a] <= {div_hi_reg[a][CB-2:0], 1'b1};
                end
                else
                begin
                    rem_hi_reg[a] <= {rem_hi_reg[a][pcw_pkg::CSZ_W-2:0], div_hi_reg[a][CB-1]};
                    div_hi_reg[a] <= {div_hi_reg[a][CB-2:0], 1'b0};
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.emit_done)
        begin
            chunk_valid   <= 1'b0;
            chunk_level   <= '0;
            level_last    <= 1'b0;
            walk_finished <= 1'b1;
            for (int a = 0; a < pcw_pkg::AXES; a++)
                chunk_index[a] <= '0;
        end
        else
        begin
            if (ctl.advance)
            begin
                chunk_valid <= 1'b1;
                chunk_level <= lvl_idx;
                level_last  <= sts.wrap_last;
                for (int a = 0; a < pcw_pkg::AXES; a++)
                    chunk_index[a] <= cursor_reg[a];
            end
            if (ctl.emit)
                walk_finished <= done_reg;
        end
    end

    // Control state: level, counters, walk bounds, cursors, done flag, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '1;
            step_cnt_reg   <= '0;
            first_step_reg <= 1'b0;
            div_cnt_reg    <= '0;
            done_reg       <= 1'b1;
            rsp_valid_reg  <= 1'b0;
            for (int a = 0; a < pcw_pkg::AXES; a++)
            begin
                bound_lo_reg[a] <= '0;
                bound_hi_reg[a] <= '0;
                cursor_reg[a]   <= '0;
            end
        end
        else
        begin
            if (ctl.start_level)
                level_reg <= levels_used - pcw_pkg::LEVEL_W'(1);
            else if (ctl.level_dec)
                level_reg <= level_reg - pcw_pkg::LEVEL_W'(1);

            if (ctl.seek_load)
            begin
                step_cnt_reg   <= lvl_idx;
                first_step_reg <= 1'b1;
            end
            else if (ctl.halve_step)
            begin
                step_cnt_reg   <= step_cnt_reg - pcw_pkg::IDX_W'(1);
                first_step_reg <= 1'b0;
            end

            if (ctl.clamp_load)
                div_cnt_reg <= '0;
            else if (ctl.div_step)
                div_cnt_reg <= div_cnt_reg + pcw_pkg::DIVCNT_W'(1);

            if (ctl.set_done)
                done_reg <= 1'b1;
            else if (ctl.commit)
                done_reg <= 1'b0;

            // New level: load bounds and put the cursor at its first chunk.
            if (ctl.commit)
            begin
                for (int a = 0; a < pcw_pkg::AXES; a++)
                begin
                    bound_lo_reg[a] <= div_lo_reg[a][SW-1:0];
                    bound_hi_reg[a] <= div_hi_reg[a][SW-1:0];
                    cursor_reg[a]   <= div_lo_reg[a][SW-1:0];
                end
            end
            else if (ctl.advance)
            begin
                // Axis 2 is x and runs fastest, then y, then z.
                if (!at_hi[2])
                    cursor_reg[2] <= cursor_reg[2] + SW'(1);
                else
                begin
                    cursor_reg[2] <= bound_lo_reg[2];
                    if (!at_hi[1])
                        cursor_reg[1] <= cursor_reg[1] + SW'(1);
                    else
                    begin
                        cursor_reg[1] <= bound_lo_reg[1];
                        cursor_reg[0] <= cursor_reg[0] + SW'(1);
                    end
                end
            end

            if (ctl.emit || ctl.emit_done)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ design/pyramid_chunk_walker.sv @@
// Top level of the pyramid chunk walker: configuration registers and the
// controller and datapath instances. Depends on pcw_pkg, pcw_ctrl and pcw_dp.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | cmd, level_index, vol_shape_*, blk_shape_*
//  rsp     | out       | rsp_valid/rsp_stall  | chunk_*, level_last, walk_finished
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// A load, or a next request that stays inside its level, is handled without leaving idle.
// A start, or a next request that ends a level, searches levels: each level tried
// passes a seek state, the halving steps, a clamp, the divider and a check;
// a finish state then closes the search.
// Reset leaves the walk finished and the level table undefined until loaded.
// Requests stall while a search runs or while a result waits to be taken.
module pyramid_chunk_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  level_index,
    input  logic [30:0] vol_shape_z,
    input  logic [30:0] vol_shape_y,
    input  logic [30:0] vol_shape_x,
    input  logic [12:0] blk_shape_z,
    input  logic [12:0] blk_shape_y,
    input  logic [12:0] blk_shape_x,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        chunk_valid,
    output logic [3:0]  chunk_level,
    output logic [30:0] chunk_index_z,
    output logic [30:0] chunk_index_y,
    output logic [30:0] chunk_index_x,
    output logic        level_last,
    output logic        walk_finished
);

    logic [pcw_pkg::COORD_BITS-1:0] begin_reg [pcw_pkg::AXES];
    logic [pcw_pkg::COORD_BITS-1:0] end_reg [pcw_pkg::AXES];
    logic [pcw_pkg::LEVEL_W-1:0]    levels_reg;
    logic                           wr_en;
    logic [2:0]                     reg_idx;
    logic [pcw_pkg::SHAPE_W-1:0]    vol_shape [pcw_pkg::AXES];
    logic [12:0]                    blk_shape [pcw_pkg::AXES];
    logic [pcw_pkg::SHAPE_W-1:0]    chunk_index [pcw_pkg::AXES];
    pcw_pkg::pcw_ctl_t              ctl;
    pcw_pkg::pcw_sts_t              sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= pcw_pkg::LEVEL_W'(1);
            for (int a = 0; a < pcw_pkg::AXES; a++)
            begin
                begin_reg[a] <= '0;
                end_reg[a]   <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pcw_pkg::REG_Z_BEGIN: begin_reg[0] <= pwdata;
                pcw_pkg::REG_Y_BEGIN: begin_reg[1] <= pwdata;
                pcw_pkg::REG_X_BEGIN: begin_reg[2] <= pwdata;
                pcw_pkg::REG_Z_END:   end_reg[0]   <= pwdata;
                pcw_pkg::REG_Y_END:   end_reg[1]   <= pwdata;
                pcw_pkg::REG_X_END:   end_reg[2]   <= pwdata;
                pcw_pkg::REG_LEVELS:  levels_reg   <= pwdata[pcw_pkg::LEVEL_W-1:0];
                default:              levels_reg   <= levels_reg;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        case (reg_idx)
            pcw_pkg::REG_Z_BEGIN: prdata = begin_reg[0];
            pcw_pkg::REG_Y_BEGIN: prdata = begin_reg[1];
            pcw_pkg::REG_X_BEGIN: prdata = begin_reg[2];
            pcw_pkg::REG_Z_END:   prdata = end_reg[0];
            pcw_pkg::REG_Y_END:   prdata = end_reg[1];
            pcw_pkg::REG_X_END:   prdata = end_reg[2];
            pcw_pkg::REG_LEVELS:  prdata = 32'(levels_reg);
            default:              prdata = '0;
        endcase
    end

    assign vol_shape[0] = vol_shape_z;
    assign vol_shape[1] = vol_shape_y;
    assign vol_shape[2] = vol_shape_x;
    assign blk_shape[0] = blk_shape_z;
    assign blk_shape[1] = blk_shape_y;
    assign blk_shape[2] = blk_shape_x;
    assign chunk_index_z = chunk_index[0];
    assign chunk_index_y = chunk_index[1];
    assign chunk_index_x = chunk_index[2];

    pcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts),
        .ctl       (ctl)
    );

    pcw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .region_begin  (begin_reg),
        .region_end    (end_reg),
        .level_count   (levels_reg),
        .level_index   (level_index),
        .vol_shape     (vol_shape),
        .blk_shape     (blk_shape),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .chunk_valid   (chunk_valid),
        .chunk_level   (chunk_level),
        .chunk_index   (chunk_index),
        .level_last    (level_last),
        .walk_finished (walk_finished)
    );

endmodule
